// ===== sv/hcp_pkg.sv =====
package hcp_pkg;

  localparam int MaxLines       = 16;
  localparam int MaxWordDigits  = 8;
  localparam int HeaderChars    = 16;
  localparam int LagLimit       = 256;
  localparam logic [7:0] EndChar = 8'd13;

  localparam int LineW  = $clog2(MaxLines);
  localparam int HdrW   = $clog2(HeaderChars);

  typedef enum logic [1:0] {
    SEC_HEADER = 2'd0,
    SEC_COUNTS = 2'd1,
    SEC_AUTO   = 2'd2,
    SEC_CROSS  = 2'd3
  } section_t;

  typedef enum logic [1:0] {
    KIND_COUNT = 2'd0,
    KIND_AUTO  = 2'd1,
    KIND_CROSS = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_OVERLONG = 2'd2,
    ST_BAD_HEX  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_DIGITS     = 2'd0,
    REG_LINES      = 2'd1,
    REG_AUTO_LAGS  = 2'd2,
    REG_CROSS_LAGS = 2'd3
  } reg_idx_t;

  // Register values outside their range: zero acts as one, anything above the top as the top.
  function automatic logic [3:0] lim_digits(input logic [3:0] v);
    if (v == 4'd0) begin
      return 4'd1;
    end else if (v > 4'(MaxWordDigits)) begin
      return 4'(MaxWordDigits);
    end
    return v;
  endfunction

  function automatic logic [4:0] lim_lines(input logic [4:0] v);
    if (v == 5'd0) begin
      return 5'd1;
    end else if (v > 5'(MaxLines)) begin
      return 5'(MaxLines);
    end
    return v;
  endfunction

  function automatic logic [8:0] lim_lags(input logic [8:0] v);
    if (v == 9'd0) begin
      return 9'd1;
    end else if (v > 9'(LagLimit)) begin
      return 9'(LagLimit);
    end
    return v;
  endfunction

  typedef struct packed {
    logic       bad;
    logic [3:0] nibble;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    r.bad    = 1'b0;
    r.nibble = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.nibble = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.nibble = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.nibble = 4'(c - 8'h57);
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== sv/hcp_char_if.sv =====
interface hcp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

// ===== sv/hcp_word_if.sv =====
interface hcp_word_if;
  logic        valid;
  logic        ready;
  logic [1:0]  word_kind;
  logic [3:0]  line_a;
  logic [3:0]  line_b;
  logic [8:0]  lag_index;
  logic [31:0] word_value;
  logic [31:0] count_ref;
  logic [1:0]  status;

  modport source (output valid, output word_kind, output line_a, output line_b,
                  output lag_index, output word_value, output count_ref,
                  output status, input ready);
  modport sink (input valid, input word_kind, input line_a, input line_b,
                input lag_index, input word_value, input count_ref,
                input status, output ready);
endinterface

// ===== sv/hex_correlation_packet_parser.sv =====
// Parses a correlator report packet arriving one ASCII character per transaction on char_ch.
// The first 16 characters are header and are skipped; then fixed-width hex words follow:
// one count per line, the autocorrelation lags of each line, then 2*cross_lag_count-1
// crosscorrelation lags for each line pair a<b. Every complete word leaves as one
// transaction on word_ch with its kind, lines, lag and reference count (the pair average for
// cross words), and a carriage return closes the packet with a status transaction. The block
// takes one character every clock cycle and a result appears in the cycle after its last
// character; the only limit is the single output register, which stalls the input while a
// result waits and word_ch is not ready. Line counts live in a small two-port store whose
// read data is prefetched at the next line indices, so no clearing pass is needed after reset.
module hex_correlation_packet_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  hcp_char_if.sink    char_ch,
  hcp_word_if.source  word_ch
);

  // Configuration registers.
  logic [3:0] digits_per_word;
  logic [4:0] line_count;
  logic [8:0] auto_lag_count;
  logic [8:0] cross_lag_count;

  // Parser state.
  hcp_pkg::section_t             section, section_next;
  logic [hcp_pkg::HdrW-1:0]      char_position, char_position_next;
  logic [3:0]                    digit_count, digit_count_next;
  logic [31:0]                   word_accumulator, word_accumulator_next;
  logic [hcp_pkg::LineW-1:0]     first_line, first_line_next;
  logic [hcp_pkg::LineW-1:0]     second_line, second_line_next;
  logic [8:0]                    lag_counter, lag_counter_next;
  logic                          bad_digit_seen, bad_digit_seen_next;
  logic                          all_done, all_done_next;
  logic                          overlong_seen, overlong_seen_next;

  // Count store and its prefetched read data for first_line and second_line.
  logic [31:0] line_counts [hcp_pkg::MaxLines];
  logic [31:0] count_a;
  logic [31:0] count_b;
  logic        mem_we;
  logic [31:0] mem_wdata;

  // Output register.
  logic        word_valid;
  logic        res_fire;
  logic [1:0]  res_kind;
  logic [3:0]  res_line_a;
  logic [3:0]  res_line_b;
  logic [8:0]  res_lag;
  logic [31:0] res_value;
  logic [31:0] res_ref;
  logic [1:0]  res_status;

  logic               char_acc;
  logic               is_end;
  hcp_pkg::hex_digit_t digit;
  logic               bad_now;
  logic [31:0]        acc_shift;
  logic [4:0]         digit_inc;
  logic               word_done;
  logic [31:0]        word_val;
  logic [31:0]        count_val;
  logic [3:0]         dpw;
  logic [4:0]         lines;
  logic [8:0]         alags;
  logic [8:0]         xwords;
  logic [9:0]         lag_inc;
  logic [4:0]         first_inc;
  logic [4:0]         second_inc;
  logic [32:0]        pair_sum;

  // ---------------------------------------------------------------- configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      digits_per_word <= 4'd8;
      line_count      <= 5'd4;
      auto_lag_count  <= 9'd8;
      cross_lag_count <= 9'd8;
    end else if (psel && penable && pwrite) begin
      unique case (hcp_pkg::reg_idx_t'(paddr[3:2]))
        hcp_pkg::REG_DIGITS:     digits_per_word <= pwdata[3:0];
        hcp_pkg::REG_LINES:      line_count      <= pwdata[4:0];
        hcp_pkg::REG_AUTO_LAGS:  auto_lag_count  <= pwdata[8:0];
        hcp_pkg::REG_CROSS_LAGS: cross_lag_count <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (hcp_pkg::reg_idx_t'(paddr[3:2]))
      hcp_pkg::REG_DIGITS:     prdata = {28'd0, digits_per_word};
      hcp_pkg::REG_LINES:      prdata = {27'd0, line_count};
      hcp_pkg::REG_AUTO_LAGS:  prdata = {23'd0, auto_lag_count};
      hcp_pkg::REG_CROSS_LAGS: prdata = {23'd0, cross_lag_count};
      default:                 prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- shared decode
  assign dpw    = hcp_pkg::lim_digits(digits_per_word);
  assign lines  = hcp_pkg::lim_lines(line_count);
  assign alags  = hcp_pkg::lim_lags(auto_lag_count);
  assign xwords = 9'({hcp_pkg::lim_lags(cross_lag_count), 1'b0} - 10'd1);

  assign char_ch.ready = !word_valid || word_ch.ready;
  assign char_acc      = char_ch.valid && char_ch.ready;
  assign is_end        = char_ch.char_in == hcp_pkg::EndChar;
  assign digit         = hcp_pkg::hex_decode(char_ch.char_in);
  assign bad_now       = bad_digit_seen || digit.bad;
  // Once a bad digit has appeared the rest of the word is not accumulated.
  assign acc_shift     = bad_now ? word_accumulator : {word_accumulator[27:0], digit.nibble};
  assign digit_inc     = {1'b0, digit_count} + 5'd1;
  assign word_done     = !is_end && !all_done && section != hcp_pkg::SEC_HEADER &&
                         digit_inc >= {1'b0, dpw};
  assign word_val      = acc_shift;
  assign count_val     = (word_val == 32'd0) ? 32'd1 : word_val;
  assign lag_inc       = {1'b0, lag_counter} + 10'd1;
  assign first_inc     = {1'b0, first_line} + 5'd1;
  assign second_inc    = {1'b0, second_line} + 5'd1;
  assign pair_sum      = {1'b0, count_a} + {1'b0, count_b};

  // ---------------------------------------------------------------- next state
  always_comb begin
    section_next          = section;
    char_position_next    = char_position;
    digit_count_next      = digit_count;
    word_accumulator_next = word_accumulator;
    first_line_next       = first_line;
    second_line_next      = second_line;
    lag_counter_next      = lag_counter;
    bad_digit_seen_next   = bad_digit_seen;
    all_done_next         = all_done;
    overlong_seen_next    = overlong_seen;
    if (char_acc) begin
      if (is_end) begin
        section_next          = hcp_pkg::SEC_HEADER;
        char_position_next    = '0;
        digit_count_next      = 4'd0;
        word_accumulator_next = 32'd0;
        first_line_next       = '0;
        second_line_next      = '0;
        lag_counter_next      = 9'd0;
        bad_digit_seen_next   = 1'b0;
        all_done_next         = 1'b0;
        overlong_seen_next    = 1'b0;
      end else if (all_done) begin
        overlong_seen_next = 1'b1;
      end else if (section == hcp_pkg::SEC_HEADER) begin
        char_position_next = char_position + 1'b1;
        if (char_position == hcp_pkg::HdrW'(hcp_pkg::HeaderChars - 1)) begin
          section_next = hcp_pkg::SEC_COUNTS;
        end
      end else if (!word_done) begin
        digit_count_next      = digit_inc[3:0];
        word_accumulator_next = acc_shift;
        bad_digit_seen_next   = bad_now;
      end else begin
        digit_count_next      = 4'd0;
        word_accumulator_next = 32'd0;
        bad_digit_seen_next   = 1'b0;
        unique case (section)
          hcp_pkg::SEC_COUNTS: begin
            first_line_next = first_inc[hcp_pkg::LineW-1:0];
            if (first_inc >= lines) begin
              first_line_next  = '0;
              lag_counter_next = 9'd0;
              section_next     = hcp_pkg::SEC_AUTO;
            end
          end
          hcp_pkg::SEC_AUTO: begin
            lag_counter_next = lag_inc[8:0];
            if (lag_inc >= {1'b0, alags}) begin
              lag_counter_next = 9'd0;
              first_line_next  = first_inc[hcp_pkg::LineW-1:0];
              if (first_inc >= lines) begin
                if (lines >= 5'd2) begin
                  section_next     = hcp_pkg::SEC_CROSS;
                  first_line_next  = '0;
                  second_line_next = hcp_pkg::LineW'(1);
                end else begin
                  all_done_next = 1'b1;
                end
              end
            end
          end
          hcp_pkg::SEC_CROSS: begin
            lag_counter_next = lag_inc[8:0];
            if (lag_inc >= {1'b0, xwords}) begin
              lag_counter_next = 9'd0;
              second_line_next = second_inc[hcp_pkg::LineW-1:0];
              if (second_inc >= lines) begin
                first_line_next  = first_inc[hcp_pkg::LineW-1:0];
                second_line_next = hcp_pkg::LineW'(first_inc + 5'd1);
                if (first_inc + 5'd1 >= lines) begin
                  all_done_next = 1'b1;
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- result
  always_comb begin
    res_fire   = 1'b0;
    res_kind   = hcp_pkg::KIND_END;
    res_line_a = 4'(first_line);
    res_line_b = 4'(first_line);
    res_lag    = 9'd0;
    res_value  = word_val;
    res_ref    = 32'd0;
    res_status = bad_now ? hcp_pkg::ST_BAD_HEX : hcp_pkg::ST_OK;
    mem_we     = 1'b0;
    mem_wdata  = count_val;
    if (char_acc && is_end) begin
      res_fire   = 1'b1;
      res_line_a = 4'd0;
      res_line_b = 4'd0;
      res_value  = 32'd0;
      if (!all_done) begin
        res_status = hcp_pkg::ST_SHORT;
      end else if (overlong_seen) begin
        res_status = hcp_pkg::ST_OVERLONG;
      end else begin
        res_status = hcp_pkg::ST_OK;
      end
    end else if (char_acc && word_done) begin
      res_fire = 1'b1;
      unique case (section)
        hcp_pkg::SEC_COUNTS: begin
          res_kind  = hcp_pkg::KIND_COUNT;
          res_value = count_val;
          res_ref   = count_val;
          mem_we    = 1'b1;
        end
        hcp_pkg::SEC_AUTO: begin
          res_kind = hcp_pkg::KIND_AUTO;
          res_lag  = lag_counter;
          res_ref  = count_a;
        end
        hcp_pkg::SEC_CROSS: begin
          res_kind   = hcp_pkg::KIND_CROSS;
          res_line_b = 4'(second_line);
          res_lag    = lag_counter;
          res_ref    = pair_sum[32:1];
        end
        default: res_fire = 1'b0;
      endcase
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      section          <= hcp_pkg::SEC_HEADER;
      char_position    <= '0;
      digit_count      <= 4'd0;
      word_accumulator <= 32'd0;
      first_line       <= '0;
      second_line      <= '0;
      lag_counter      <= 9'd0;
      bad_digit_seen   <= 1'b0;
      all_done         <= 1'b0;
      overlong_seen    <= 1'b0;
    end else begin
      section          <= section_next;
      char_position    <= char_position_next;
      digit_count      <= digit_count_next;
      word_accumulator <= word_accumulator_next;
      first_line       <= first_line_next;
      second_line      <= second_line_next;
      lag_counter      <= lag_counter_next;
      bad_digit_seen   <= bad_digit_seen_next;
      all_done         <= all_done_next;
      overlong_seen    <= overlong_seen_next;
    end
  end

  // The store is read at the next line indices so that count_a and count_b always match
  // first_line and second_line; a write to the same entry is forwarded.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_counts[first_line] <= mem_wdata;
    end
    if (mem_we && first_line == first_line_next) begin
      count_a <= mem_wdata;
    end else begin
      count_a <= line_counts[first_line_next];
    end
    if (mem_we && first_line == second_line_next) begin
      count_b <= mem_wdata;
    end else begin
      count_b <= line_counts[second_line_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (res_fire) begin
      word_valid <= 1'b1;
    end else if (word_ch.ready) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      word_ch.word_kind  <= res_kind;
      word_ch.line_a     <= res_line_a;
      word_ch.line_b     <= res_line_b;
      word_ch.lag_index  <= res_lag;
      word_ch.word_value <= res_value;
      word_ch.count_ref  <= res_ref;
      word_ch.status     <= res_status;
    end
  end

  assign word_ch.valid = word_valid;

`ifndef SYNTHESIS
  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    char_acc && is_end |=> section == hcp_pkg::SEC_HEADER && !all_done && !overlong_seen)
    else $error("packet end did not restart the parser");

  a_cross_order: assert property (@(posedge clk) disable iff (rst)
    section == hcp_pkg::SEC_CROSS && !all_done |-> first_line < second_line)
    else $error("cross pair out of order");

  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    char_acc && all_done && !is_end |-> !res_fire)
    else $error("word produced after the last word of the packet");

  a_digit_bound: assert property (@(posedge clk) disable iff (rst)
    digit_count < 4'(hcp_pkg::MaxWordDigits))
    else $error("digit counter beyond word width");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    word_valid && !word_ch.ready |-> !res_fire)
    else $error("pending result overwritten");
`endif

endmodule
